// File: src/hsv_to_rgb_packed_core_macros.svh
// Assertion macros shared by the HSV to RGB checker.
`ifndef HSV_TO_RGB_PACKED_CORE_MACROS_SVH
`define HSV_TO_RGB_PACKED_CORE_MACROS_SVH

// Checked on every edge outside reset.
`define HSV2RGB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define HSV2RGB_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: src/hsv2rgb_pkg.sv
// Shared types and constants of the HSV to RGB converter.
package hsv2rgb_pkg;

   localparam logic [16:0] HUE_FULL    = 17'd92160;     // 360.0 degrees, Q9.8
   localparam logic [16:0] UNIT        = 17'd65536;     // 1.0 in Q1.16
   localparam logic [13:0] SECTOR_SPAN = 14'd15360;     // 60.0 degrees, Q9.8
   localparam logic [29:0] TERM_ONE    = 30'd1006632960; // UNIT * SECTOR_SPAN

   typedef enum logic [2:0] {
      SECTOR_0 = 3'd0,
      SECTOR_1 = 3'd1,
      SECTOR_2 = 3'd2,
      SECTOR_3 = 3'd3,
      SECTOR_4 = 3'd4,
      SECTOR_5 = 3'd5
   } sector_type;

   typedef struct packed {
      sector_type  sector;
      logic [13:0] rem;
      logic [16:0] sat;
      logic [16:0] val;
   } sect_stage_type;

   typedef struct packed {
      sector_type  sector;
      logic [16:0] val;
      logic [29:0] pn;
      logic [29:0] qn;
      logic [29:0] tn;
   } term_stage_type;

   typedef struct packed {
      sector_type  sector;
      logic [16:0] val;
      logic [46:0] pp;
      logic [46:0] pq;
      logic [46:0] pt;
   } prod_stage_type;

endpackage

// File: src/hsv2rgb_if.sv
// Valid/ready channels carrying HSV requests and packed RGB responses.
interface hsv2rgb_req_if;
   logic        valid;
   logic        ready;
   logic [16:0] hue;
   logic [16:0] saturation;
   logic [16:0] brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   output ready);
endinterface

interface hsv2rgb_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] color;

   modport source (output valid, output color, input ready);
   modport sink   (input valid, input color, output ready);
endinterface

// File: src/hsv2rgb_sector.sv
// Stage 1: clamp inputs, wrap hue, split hue into sector and remainder.
module hsv2rgb_sector (
   input  logic                        clock,
   input  logic                        load,
   input  logic [16:0]                 hue,
   input  logic [16:0]                 saturation,
   input  logic [16:0]                 brightness,
   output hsv2rgb_pkg::sect_stage_type stage_ff
);

   logic [16:0]                 hue_c;
   logic [16:0]                 base;
   hsv2rgb_pkg::sector_type     sector;
   hsv2rgb_pkg::sect_stage_type stage_in;

   always_comb begin
      // 360 degrees and anything above it fold to 0
      hue_c = (hue >= hsv2rgb_pkg::HUE_FULL) ? 17'd0 : hue;
      if (hue_c >= 17'd76800) begin
         sector = hsv2rgb_pkg::SECTOR_5;
         base   = 17'd76800;
      end else if (hue_c >= 17'd61440) begin
         sector = hsv2rgb_pkg::SECTOR_4;
         base   = 17'd61440;
      end else if (hue_c >= 17'd46080) begin
         sector = hsv2rgb_pkg::SECTOR_3;
         base   = 17'd46080;
      end else if (hue_c >= 17'd30720) begin
         sector = hsv2rgb_pkg::SECTOR_2;
         base   = 17'd30720;
      end else if (hue_c >= {3'd0, hsv2rgb_pkg::SECTOR_SPAN}) begin
         sector = hsv2rgb_pkg::SECTOR_1;
         base   = {3'd0, hsv2rgb_pkg::SECTOR_SPAN};
      end else begin
         sector = hsv2rgb_pkg::SECTOR_0;
         base   = 17'd0;
      end
      stage_in.sector = sector;
      stage_in.rem    = 14'(hue_c - base);
      stage_in.sat    = (saturation > hsv2rgb_pkg::UNIT) ? hsv2rgb_pkg::UNIT : saturation;
      stage_in.val    = (brightness > hsv2rgb_pkg::UNIT) ? hsv2rgb_pkg::UNIT : brightness;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

endmodule

// File: src/hsv2rgb_terms.sv
// Stage 2: numerators of p, q and t, scaled by UNIT * SECTOR_SPAN.
module hsv2rgb_terms (
   input  logic                        clock,
   input  logic                        load,
   input  hsv2rgb_pkg::sect_stage_type src,
   output hsv2rgb_pkg::term_stage_type stage_ff
);

   logic [16:0]                 one_minus_s;
   logic [13:0]                 rem_inv;
   logic [30:0]                 s_rem;
   logic [30:0]                 s_inv;
   logic [30:0]                 p_full;
   hsv2rgb_pkg::term_stage_type stage_in;

   always_comb begin
      one_minus_s = hsv2rgb_pkg::UNIT - src.sat;
      rem_inv     = hsv2rgb_pkg::SECTOR_SPAN - src.rem;
      s_rem       = {14'd0, src.sat} * {17'd0, src.rem};
      s_inv       = {14'd0, src.sat} * {17'd0, rem_inv};
      p_full      = {14'd0, one_minus_s} * {17'd0, hsv2rgb_pkg::SECTOR_SPAN};

      stage_in.sector = src.sector;
      stage_in.val    = src.val;
      stage_in.pn     = p_full[29:0];
      stage_in.qn     = hsv2rgb_pkg::TERM_ONE - s_rem[29:0];
      stage_in.tn     = hsv2rgb_pkg::TERM_ONE - s_inv[29:0];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

endmodule

// File: src/hsv2rgb_mult.sv
// Stage 3: value times each term numerator.
module hsv2rgb_mult (
   input  logic                        clock,
   input  logic                        load,
   input  hsv2rgb_pkg::term_stage_type src,
   output hsv2rgb_pkg::prod_stage_type stage_ff
);

   hsv2rgb_pkg::prod_stage_type stage_in;

   always_comb begin
      stage_in.sector = src.sector;
      stage_in.val    = src.val;
      stage_in.pp     = {30'd0, src.val} * {17'd0, src.pn};
      stage_in.pq     = {30'd0, src.val} * {17'd0, src.qn};
      stage_in.pt     = {30'd0, src.val} * {17'd0, src.tn};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

endmodule

// File: src/hsv2rgb_route.sv
// Stage 4: scale to 8-bit channels, route by sector, pack the colour.
module hsv2rgb_route (
   input  logic                        clock,
   input  logic                        load,
   input  hsv2rgb_pkg::prod_stage_type src,
   output logic [23:0]                 color_ff
);

   // 255 / (UNIT^2 * SECTOR_SPAN) reduces to 17 / 2^42, so scaling is exact
   function automatic logic [7:0] chan_level(input logic [46:0] prod);
      logic [51:0] ext;
      logic [51:0] sum;
      ext = {5'd0, prod};
      sum = (ext << 4) + ext;
      return sum[49:42];
   endfunction

   logic [24:0] v_scaled;
   logic [7:0]  vc;
   logic [7:0]  pc;
   logic [7:0]  qc;
   logic [7:0]  tc;
   logic [23:0] color_in;

   always_comb begin
      v_scaled = {8'd0, src.val} * 25'd255;
      vc       = v_scaled[23:16];
      pc       = chan_level(src.pp);
      qc       = chan_level(src.pq);
      tc       = chan_level(src.pt);
      case (src.sector)
         hsv2rgb_pkg::SECTOR_0: color_in = {vc, tc, pc};
         hsv2rgb_pkg::SECTOR_1: color_in = {qc, vc, pc};
         hsv2rgb_pkg::SECTOR_2: color_in = {pc, vc, tc};
         hsv2rgb_pkg::SECTOR_3: color_in = {pc, qc, vc};
         hsv2rgb_pkg::SECTOR_4: color_in = {tc, pc, vc};
         default:               color_in = {vc, pc, qc};
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         color_ff <= color_in;
      end
   end

endmodule

// File: src/hsv_to_rgb_packed_core.sv
// HSV to packed RGB converter, four register stages.
// Path: a request passes the sector, terms, product and output colour registers in order before the response is valid.
// Throughput: one colour per cycle while the receiver is ready; each stage holds while the next is full and stalled.
// Empty stages take new data even while the response waits, so bubbles close up.
// Reset (synchronous) clears the stage valid bits only; no stored state otherwise.
module hsv_to_rgb_packed_core (
   input  logic                 clock,
   input  logic                 reset,
   hsv2rgb_req_if.sink          req_chan,
   hsv2rgb_rsp_if.source        rsp_chan
);

   // Stage valid bits: sector, terms, products, output colour
   logic valid1_ff, valid2_ff, valid3_ff, valid4_ff;
   logic valid1_in, valid2_in, valid3_in, valid4_in;
   // A stage can load when it is empty or its content moves on this cycle
   logic load1, load2, load3, load4;

   hsv2rgb_pkg::sect_stage_type sect_q;
   hsv2rgb_pkg::term_stage_type term_q;
   hsv2rgb_pkg::prod_stage_type prod_q;

   always_comb begin
      load4 = !valid4_ff || rsp_chan.ready;
      load3 = !valid3_ff || load4;
      load2 = !valid2_ff || load3;
      load1 = !valid1_ff || load2;

      valid1_in = load1 ? req_chan.valid : valid1_ff;
      valid2_in = load2 ? valid1_ff      : valid2_ff;
      valid3_in = load3 ? valid2_ff      : valid3_ff;
      valid4_in = load4 ? valid3_ff      : valid4_ff;
   end

   assign req_chan.ready = load1;
   assign rsp_chan.valid = valid4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
         valid2_ff <= valid2_in;
         valid3_ff <= valid3_in;
         valid4_ff <= valid4_in;
      end
   end

   // Clamp, hue wrap, sector split
   hsv2rgb_sector u_sector (
      .clock      (clock),
      .load       (load1),
      .hue        (req_chan.hue),
      .saturation (req_chan.saturation),
      .brightness (req_chan.brightness),
      .stage_ff   (sect_q)
   );

   // p, q, t numerators; zero saturation falls out as grey with no special case
   hsv2rgb_terms u_terms (
      .clock    (clock),
      .load     (load2),
      .src      (sect_q),
      .stage_ff (term_q)
   );

   // Value times numerators, 17 x 30 bits each
   hsv2rgb_mult u_mult (
      .clock    (clock),
      .load     (load3),
      .src      (term_q),
      .stage_ff (prod_q)
   );

   // Exact truncating scale to 8 bits, sector routing, packing
   hsv2rgb_route u_route (
      .clock    (clock),
      .load     (load4),
      .src      (prod_q),
      .color_ff (rsp_chan.color)
   );

endmodule

// File: src/hsv2rgb_checker.sv
// Port-level checks on the HSV to RGB converter, bound to the top level.
`include "hsv_to_rgb_packed_core_macros.svh"

module hsv2rgb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [23:0] color
);

   logic req_xfer;
   logic rsp_stall;
   logic quiet;

   assign req_xfer  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   // no request transfer and the receiver taking whatever comes
   assign quiet     = !req_xfer && rsp_ready;

   `HSV2RGB_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "response valid after reset")
   `HSV2RGB_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(color), "stalled response changed")
   `HSV2RGB_ASSERT(a_latency, req_xfer ##1 rsp_ready [*3] |=> rsp_valid, "response late")
   `HSV2RGB_ASSERT(a_drain, quiet [*4] |=> !rsp_valid, "response without request")

endmodule

bind hsv_to_rgb_packed_core hsv2rgb_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .color     (rsp_chan.color)
);
